### sv/dcc_pkg.sv
package dcc_pkg;

    localparam int ROW_W          = 32;
    localparam int CFG_W          = 6;
    localparam int CLASS_W        = 2;
    localparam int MAX_NODES_DEF  = 32;
    localparam int NODE_COUNT_RST = 32;
    localparam int UPC_W          = 5;

    localparam logic [CLASS_W-1:0] CLS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_WEAK   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_UNI    = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_STRONG = 2'd3;

    localparam logic BANK_REACH = 1'b0;
    localparam logic BANK_SYM   = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_C_INIT,
        OP_C_RDK,
        OP_C_PIV,
        OP_C_ITER,
        OP_C_KNEXT,
        OP_T_INIT,
        OP_T_RDJ,
        OP_T_LDJ,
        OP_T_ITER,
        OP_T_WR,
        OP_W_RD,
        OP_W_CHK,
        OP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        J_NONE,
        J_ALWAYS,
        J_NOT_START,
        J_NOT_ILAST,
        J_NOT_KLAST,
        J_UNI,
        J_OUT_BUSY
    } t_jcond;

    typedef struct packed {
        t_uop             op;
        logic             bank;
        t_jcond           jc;
        logic [UPC_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic inner_last;
        logic outer_last;
        logic uni;
    } t_dp_status;

    localparam logic [UPC_W-1:0] UA_IDLE     = 5'd0;
    localparam logic [UPC_W-1:0] UA_C0_INIT  = 5'd1;
    localparam logic [UPC_W-1:0] UA_C0_RDK   = 5'd2;
    localparam logic [UPC_W-1:0] UA_C0_PIV   = 5'd3;
    localparam logic [UPC_W-1:0] UA_C0_ITER  = 5'd4;
    localparam logic [UPC_W-1:0] UA_C0_KNEXT = 5'd5;
    localparam logic [UPC_W-1:0] UA_T_INIT   = 5'd6;
    localparam logic [UPC_W-1:0] UA_T_RDJ    = 5'd7;
    localparam logic [UPC_W-1:0] UA_T_LDJ    = 5'd8;
    localparam logic [UPC_W-1:0] UA_T_ITER   = 5'd9;
    localparam logic [UPC_W-1:0] UA_T_WR     = 5'd10;
    localparam logic [UPC_W-1:0] UA_DECIDE   = 5'd11;
    localparam logic [UPC_W-1:0] UA_C1_INIT  = 5'd12;
    localparam logic [UPC_W-1:0] UA_C1_RDK   = 5'd13;
    localparam logic [UPC_W-1:0] UA_C1_PIV   = 5'd14;
    localparam logic [UPC_W-1:0] UA_C1_ITER  = 5'd15;
    localparam logic [UPC_W-1:0] UA_C1_KNEXT = 5'd16;
    localparam logic [UPC_W-1:0] UA_W_RD     = 5'd17;
    localparam logic [UPC_W-1:0] UA_W_CHK    = 5'd18;
    localparam logic [UPC_W-1:0] UA_EMIT     = 5'd19;
    localparam logic [UPC_W-1:0] UA_RET      = 5'd20;
    localparam logic [UPC_W-1:0] UA_LAST     = UA_RET;

    function automatic t_uword uw(t_uop op, logic bank, t_jcond jc,
                                  logic [UPC_W-1:0] tgt);
        t_uword w;
        w.op   = op;
        w.bank = bank;
        w.jc   = jc;
        w.tgt  = tgt;
        return w;
    endfunction

    // control store: closure of the loaded rows, symmetrize, optional second closure and weak check, emit
    function automatic t_uword ucode(logic [UPC_W-1:0] a);
        t_uword w;
        case (a)
            UA_IDLE:     w = uw(OP_NOP,     BANK_REACH, J_NOT_START, UA_IDLE);
            UA_C0_INIT:  w = uw(OP_C_INIT,  BANK_REACH, J_NONE,      UA_IDLE);
            UA_C0_RDK:   w = uw(OP_C_RDK,   BANK_REACH, J_NONE,      UA_IDLE);
            UA_C0_PIV:   w = uw(OP_C_PIV,   BANK_REACH, J_NONE,      UA_IDLE);
            UA_C0_ITER:  w = uw(OP_C_ITER,  BANK_REACH, J_NOT_ILAST, UA_C0_ITER);
            UA_C0_KNEXT: w = uw(OP_C_KNEXT, BANK_REACH, J_NOT_KLAST, UA_C0_RDK);
            UA_T_INIT:   w = uw(OP_T_INIT,  BANK_REACH, J_NONE,      UA_IDLE);
            UA_T_RDJ:    w = uw(OP_T_RDJ,   BANK_REACH, J_NONE,      UA_IDLE);
            UA_T_LDJ:    w = uw(OP_T_LDJ,   BANK_REACH, J_NONE,      UA_IDLE);
            UA_T_ITER:   w = uw(OP_T_ITER,  BANK_REACH, J_NOT_ILAST, UA_T_ITER);
            UA_T_WR:     w = uw(OP_T_WR,    BANK_SYM,   J_NOT_KLAST, UA_T_RDJ);
            UA_DECIDE:   w = uw(OP_NOP,     BANK_SYM,   J_UNI,       UA_EMIT);
            UA_C1_INIT:  w = uw(OP_C_INIT,  BANK_SYM,   J_NONE,      UA_IDLE);
            UA_C1_RDK:   w = uw(OP_C_RDK,   BANK_SYM,   J_NONE,      UA_IDLE);
            UA_C1_PIV:   w = uw(OP_C_PIV,   BANK_SYM,   J_NONE,      UA_IDLE);
            UA_C1_ITER:  w = uw(OP_C_ITER,  BANK_SYM,   J_NOT_ILAST, UA_C1_ITER);
            UA_C1_KNEXT: w = uw(OP_C_KNEXT, BANK_SYM,   J_NOT_KLAST, UA_C1_RDK);
            UA_W_RD:     w = uw(OP_W_RD,    BANK_SYM,   J_NONE,      UA_IDLE);
            UA_W_CHK:    w = uw(OP_W_CHK,   BANK_SYM,   J_NONE,      UA_IDLE);
            UA_EMIT:     w = uw(OP_EMIT,    BANK_SYM,   J_OUT_BUSY,  UA_EMIT);
            UA_RET:      w = uw(OP_NOP,     BANK_REACH, J_ALWAYS,    UA_IDLE);
            default:     w = uw(OP_NOP,     BANK_REACH, J_ALWAYS,    UA_IDLE);
        endcase
        return w;
    endfunction

endpackage

### sv/dcc_sequencer.sv
module dcc_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_out_busy,
    input  dcc_pkg::t_dp_status i_status,
    output dcc_pkg::t_uword     o_cw,
    output logic                o_idle
);
    import dcc_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           cw;
    logic             take;

    assign cw = ucode(r_upc);

    always_comb begin
        case (cw.jc)
            J_NONE:      take = 1'b0;
            J_ALWAYS:    take = 1'b1;
            J_NOT_START: take = !i_start;
            J_NOT_ILAST: take = !i_status.inner_last;
            J_NOT_KLAST: take = !i_status.outer_last;
            J_UNI:       take = i_status.uni;
            J_OUT_BUSY:  take = i_out_busy;
            default:     take = 1'b1;
        endcase
        n_upc = take ? cw.tgt : r_upc + 1'b1;
    end

    always_comb begin
        o_cw   = cw;
        o_idle = (r_upc == UA_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc <= UA_LAST)
        else $error("step counter outside the control store");

endmodule

### sv/dcc_datapath.sv
module dcc_datapath #(
    parameter int MAX_NODES = dcc_pkg::MAX_NODES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dcc_pkg::t_uword                i_cw,
    input  logic [$clog2(MAX_NODES)-1:0]   i_last,
    input  logic                           i_ld_we,
    input  logic [$clog2(MAX_NODES)-1:0]   i_ld_idx,
    input  logic [MAX_NODES-1:0]           i_ld_row,
    output dcc_pkg::t_dp_status            o_status,
    output logic [dcc_pkg::CLASS_W-1:0]    o_class
);
    import dcc_pkg::*;

    localparam int AW = $clog2(MAX_NODES);

    // two banks: reachability rows, then symmetric rows
    logic [MAX_NODES-1:0] r_mem [2**(AW+1)];

    logic [MAX_NODES-1:0] r_rd;
    logic [MAX_NODES-1:0] r_piv, n_piv;
    logic [MAX_NODES-1:0] r_row, n_row;
    logic [MAX_NODES-1:0] r_acc, n_acc;
    logic [AW-1:0]        r_k, n_k;
    logic [AW-1:0]        r_i, n_i;
    logic [AW-1:0]        r_wi, n_wi;
    logic                 r_bank, n_bank;
    logic                 r_pend, n_pend;
    logic                 r_tpend, n_tpend;
    logic                 r_strong, n_strong;
    logic                 r_uni, n_uni;
    logic                 r_weak, n_weak;

    logic [MAX_NODES-1:0] full;
    logic [MAX_NODES-1:0] onehot_k;
    logic [MAX_NODES-1:0] bit0;
    logic [MAX_NODES-1:0] acc_now;
    logic                 rd_en;
    logic [AW:0]          rd_addr;
    logic                 wr_en;
    logic [AW:0]          wr_addr;
    logic [MAX_NODES-1:0] wr_data;
    logic                 sym_ok;

    always_comb begin
        for (int b = 0; b < MAX_NODES; b++) begin
            full[b]     = (AW'(b) <= i_last);
            onehot_k[b] = (AW'(b) == r_k);
            bit0[b]     = (b == 0);
        end
    end

    // column bit of the pending transpose read lands this cycle
    always_comb begin
        acc_now = r_acc;
        if (r_tpend) begin
            acc_now[r_wi] = r_rd[r_k];
        end
    end

    assign sym_ok = (((acc_now | r_row | onehot_k) & full) == full);

    always_comb begin
        case (i_cw.op)
            OP_C_RDK: begin
                rd_en   = 1'b1;
                rd_addr = {r_bank, r_k};
            end
            OP_C_ITER: begin
                rd_en   = 1'b1;
                rd_addr = {r_bank, r_i};
            end
            OP_T_RDJ: begin
                rd_en   = 1'b1;
                rd_addr = {BANK_REACH, r_k};
            end
            OP_T_ITER: begin
                rd_en   = 1'b1;
                rd_addr = {BANK_REACH, r_i};
            end
            OP_W_RD: begin
                rd_en   = 1'b1;
                rd_addr = {BANK_SYM, {AW{1'b0}}};
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = {BANK_REACH, r_i};
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {BANK_REACH, i_ld_idx};
        wr_data = i_ld_row & full;
        if (i_ld_we) begin
            wr_en = 1'b1;
        end else if (r_pend && r_rd[r_k]) begin
            // row i reaches pivot k, so it reaches everything k reaches
            wr_en   = 1'b1;
            wr_addr = {r_bank, r_wi};
            wr_data = r_rd | r_piv;
        end else if (i_cw.op == OP_T_WR) begin
            wr_en   = 1'b1;
            wr_addr = {BANK_SYM, r_k};
            wr_data = acc_now | r_row;
        end
    end

    always_comb begin
        n_piv    = r_piv;
        n_row    = r_row;
        n_acc    = acc_now;
        n_k      = r_k;
        n_i      = r_i;
        n_wi     = r_wi;
        n_bank   = r_bank;
        n_pend   = 1'b0;
        n_tpend  = 1'b0;
        n_strong = r_strong;
        n_uni    = r_uni;
        n_weak   = r_weak;
        case (i_cw.op)
            OP_C_INIT: begin
                n_bank = i_cw.bank;
                n_k    = '0;
            end
            OP_C_RDK: begin
                n_i = '0;
            end
            OP_C_PIV: begin
                n_piv = r_rd;
            end
            OP_C_ITER: begin
                n_pend = 1'b1;
                n_wi   = r_i;
                n_i    = r_i + 1'b1;
            end
            OP_C_KNEXT: begin
                n_k = r_k + 1'b1;
            end
            OP_T_INIT: begin
                n_k      = '0;
                n_strong = 1'b1;
                n_uni    = 1'b1;
            end
            OP_T_RDJ: begin
                n_i   = '0;
                n_acc = '0;
            end
            OP_T_LDJ: begin
                n_row = r_rd;
                if ((r_rd & full) != full) begin
                    n_strong = 1'b0;
                end
            end
            OP_T_ITER: begin
                n_tpend = 1'b1;
                n_wi    = r_i;
                n_i     = r_i + 1'b1;
            end
            OP_T_WR: begin
                if (!sym_ok) begin
                    n_uni = 1'b0;
                end
                n_k = r_k + 1'b1;
            end
            OP_W_CHK: begin
                n_weak = (((r_rd | bit0) & full) == full);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_tpend  <= 1'b0;
            r_strong <= 1'b0;
            r_uni    <= 1'b0;
            r_weak   <= 1'b0;
        end else begin
            r_pend   <= n_pend;
            r_tpend  <= n_tpend;
            r_strong <= n_strong;
            r_uni    <= n_uni;
            r_weak   <= n_weak;
        end
    end

    always_ff @(posedge i_clk) begin
        r_piv  <= n_piv;
        r_row  <= n_row;
        r_acc  <= n_acc;
        r_k    <= n_k;
        r_i    <= n_i;
        r_wi   <= n_wi;
        r_bank <= n_bank;
    end

    always_comb begin
        o_status.inner_last = (r_i == i_last);
        o_status.outer_last = (r_k == i_last);
        o_status.uni        = r_uni;
        if (r_strong) begin
            o_class = CLS_STRONG;
        end else if (r_uni) begin
            o_class = CLS_UNI;
        end else if (r_weak) begin
            o_class = CLS_WEAK;
        end else begin
            o_class = CLS_NONE;
        end
    end

    a_pend_from_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(i_cw.op) == OP_C_ITER)
        else $error("closure write-back without a preceding row read");

    a_no_load_in_closure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_ld_we)
        else $error("row load collides with closure write-back");

endmodule

### sv/digraph_connectivity_classifier_top.sv
// Directed graph connectivity classifier.
// Input channel (i_valid / o_stall): one adjacency row per beat, row 0 first;
// bit j of i_row_bits is an edge from this row's node to node j. Bits at or
// above the node count are ignored. After node_count rows the graph is closed
// (Warshall, one row OR per cycle from a two-port row store) and classified.
// Output channel (o_valid / i_stall): one beat per graph carrying
// o_connectivity_class: 0 none, 1 weak, 2 unilateral, 3 strong.
// Config: i_cfg_we writes node_count (0 acts as 1, above MAX_NODES saturates)
// and restarts loading at row 0; write only while the block is idle.
// Flow for n nodes: rows load at one per cycle while o_stall is low; the
// microprogram then closes the graph and builds the symmetric rows, and when
// the graph is neither strongly nor unilaterally connected it runs a second
// closure over the symmetric rows. Each of the n outer steps runs n inner row
// updates through the row store.
// o_stall is high while the microprogram runs. A finished result sits in the
// output register; while i_stall holds it, new rows still load, and the next
// graph's program waits at its final step until the register is free.
// Reset: synchronous active low; node_count returns to 32 (or MAX_NODES if
// smaller), loading restarts at row 0 and no result is pending.
module digraph_connectivity_classifier_top #(
    parameter int MAX_NODES = dcc_pkg::MAX_NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [dcc_pkg::ROW_W-1:0]     i_row_bits,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dcc_pkg::CLASS_W-1:0]   o_connectivity_class,
    input  logic                          i_cfg_we,
    input  logic [dcc_pkg::CFG_W-1:0]     i_cfg_data
);
    import dcc_pkg::*;

    localparam int AW    = $clog2(MAX_NODES);
    localparam int RST_N = (NODE_COUNT_RST > MAX_NODES) ? MAX_NODES : NODE_COUNT_RST;

    logic [AW-1:0]        r_load, n_load;
    logic [AW-1:0]        r_last, n_last;
    logic                 r_ovalid, n_ovalid;
    logic [CLASS_W-1:0]   r_class, n_class;

    logic [AW-1:0]        cfg_last;
    logic [CFG_W:0]       cfg_ext;
    logic [MAX_NODES-1:0] row_ext;
    logic                 accept;
    logic                 start;
    logic                 out_busy;
    logic                 emit;
    logic                 idle;
    t_uword               cw;
    t_dp_status           status;
    logic [CLASS_W-1:0]   dp_class;

    generate
        if (MAX_NODES > ROW_W) begin : g_row_wide
            assign row_ext = {{(MAX_NODES-ROW_W){1'b0}}, i_row_bits};
        end else if (MAX_NODES == ROW_W) begin : g_row_eq
            assign row_ext = i_row_bits;
        end else begin : g_row_narrow
            assign row_ext = i_row_bits[MAX_NODES-1:0];
        end
    endgenerate

    assign cfg_ext = {1'b0, i_cfg_data};

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_last = '0;
        end else if (cfg_ext > (CFG_W+1)'(MAX_NODES)) begin
            cfg_last = AW'(MAX_NODES - 1);
        end else begin
            cfg_last = AW'(i_cfg_data - CFG_W'(1));
        end
    end

    assign o_stall  = !idle;
    assign accept   = i_valid && !o_stall;
    assign start    = accept && (r_load == r_last);
    assign out_busy = r_ovalid && i_stall;
    assign emit     = (cw.op == OP_EMIT) && !out_busy;

    always_comb begin
        n_load   = r_load;
        n_last   = r_last;
        n_ovalid = r_ovalid;
        n_class  = r_class;
        if (i_cfg_we) begin
            n_last = cfg_last;
            n_load = '0;
        end else if (accept) begin
            n_load = start ? '0 : r_load + 1'b1;
        end
        if (emit) begin
            n_ovalid = 1'b1;
            n_class  = dp_class;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load   <= '0;
            r_last   <= AW'(RST_N - 1);
            r_ovalid <= 1'b0;
        end else begin
            r_load   <= n_load;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_class <= n_class;
    end

    assign o_valid              = r_ovalid;
    assign o_connectivity_class = r_class;

    dcc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_busy (out_busy),
        .i_status   (status),
        .o_cw       (cw),
        .o_idle     (idle)
    );

    dcc_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cw     (cw),
        .i_last   (r_last),
        .i_ld_we  (accept),
        .i_ld_idx (r_load),
        .i_ld_row (row_ext),
        .o_status (status),
        .o_class  (dp_class)
    );

    a_start_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !i_cfg_we |=> o_stall)
        else $error("last row taken but classification did not start");

    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load <= r_last)
        else $error("row counter beyond node count");

endmodule
